// ===== sv/dsa_pkg.sv =====
// Package: shared widths, codes, table entry layout and controller/datapath links.
`timescale 1ns / 1ps
package dsa_pkg;

  localparam int SLOT_W    = 6;
  localparam int DUR_W     = 32;
  localparam int DL_W      = 40;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;
  localparam int SLOT_SPAN = 64;   // slots reachable through a SLOT_W index
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_ADMIT      = 2'd0,
    STS_OWN_LATE   = 2'd1,
    STS_LATER_LATE = 2'd2,
    STS_TAKEN      = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // One table entry: admitted duration and its current slack
  typedef struct packed {
    logic [DUR_W-1:0] duration;
    logic [DL_W-1:0]  slack;
  } entry_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;        // capture the offered beat
    logic walk_start;  // rewind the table walk
    logic walk_en;     // advance the table walk
    logic upd_mode;    // walk lowers later slack instead of scanning
    logic reject;      // post a slot-taken result
    logic decide;      // post the test outcome, commit on admission
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic taken;       // slot out of range or already valid
    logic walk_done;   // walk issued every entry and drained
    logic pass_ok;     // both admission tests passed
  } sts_t;

endpackage

// ===== sv/dsa_ctrl.sv =====
// Controller: sequences the check, scan, decision and slack update of one offer.
`timescale 1ns / 1ps
module dsa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  dsa_pkg::sts_t sts,
  output dsa_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);
  import dsa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.taken ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.walk_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = sts.pass_ok ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        if (sts.walk_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CHECK: begin
        cmd.reject     = sts.taken;
        cmd.walk_start = !sts.taken;
      end
      ST_SCAN: begin
        cmd.walk_en = 1'b1;
      end
      ST_DECIDE: begin
        cmd.decide     = 1'b1;
        cmd.walk_start = 1'b1;
      end
      ST_UPDATE: begin
        cmd.walk_en  = 1'b1;
        cmd.upd_mode = 1'b1;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ===== sv/dsa_datapath.sv =====
// Datapath: slot table memory, valid bits, walk counter, tests and result registers.
`timescale 1ns / 1ps
module dsa_datapath #(
  parameter int SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsa_pkg::cmd_t                 cmd,
  input  logic [dsa_pkg::SLOT_W-1:0]    in_slot,
  input  logic [dsa_pkg::DUR_W-1:0]     in_duration,
  input  logic [dsa_pkg::DL_W-1:0]      in_deadline,
  output dsa_pkg::sts_t                 sts,
  output logic [dsa_pkg::STATUS_W-1:0]  out_status,
  output logic [dsa_pkg::COUNT_W-1:0]   out_admitted_count,
  output logic [dsa_pkg::DL_W-1:0]      out_new_slack
);
  import dsa_pkg::*;

  // Only slots reachable through the index field are ever stored
  localparam int DEPTH = (SLOTS < SLOT_SPAN) ? SLOTS : SLOT_SPAN;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int WLK_W = $clog2(DEPTH + 1);
  localparam logic [WLK_W-1:0] WLK_END = WLK_W'(DEPTH);

  // Slot table and valid bits
  entry_t               mem [DEPTH];
  logic [DEPTH-1:0]     valid_r;

  // Offered beat
  logic [SLOT_W-1:0]    slot_r;
  logic [DUR_W-1:0]     dur_r;
  logic [DL_W-1:0]      dl_r;

  // Walk pipeline
  logic [WLK_W-1:0]     wlk_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  entry_t               rd_data_r;

  // Accumulators
  logic [DL_W-1:0]      need_r;
  logic                 late_r;
  logic [COUNT_W-1:0]   count_r;

  // Results
  status_t              res_status_r;
  logic [COUNT_W-1:0]   res_count_r;
  logic [DL_W-1:0]      res_slack_r;

  logic [IDX_W-1:0]     pos;
  logic                 slot_bad;
  logic                 issue;
  logic                 hit_valid;
  logic                 own_late;
  logic [COUNT_W-1:0]   count_inc;
  logic                 upd_we;
  logic                 commit_we;

  assign pos       = slot_r[IDX_W-1:0];
  assign slot_bad  = {{(32-SLOT_W){1'b0}}, slot_r} >= 32'(SLOTS);
  assign issue     = cmd.walk_en && (wlk_r < WLK_END);
  assign hit_valid = rd_vld_r && valid_r[rd_idx_r];
  assign own_late  = need_r > dl_r;
  assign count_inc = (count_r != COUNT_MAX) ? count_r + 7'd1 : count_r;
  assign upd_we    = cmd.upd_mode && hit_valid && (rd_idx_r > pos);
  assign commit_we = cmd.decide && sts.pass_ok;

  assign sts = '{taken:     slot_bad || valid_r[pos],
                 walk_done: (wlk_r == WLK_END) && !rd_vld_r,
                 pass_ok:   !own_late && !late_r};

  // Capture the offered beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r <= in_slot;
      dur_r  <= in_duration;
      dl_r   <= in_deadline;
    end
  end

  // Advance the walk counter and track reads in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlk_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.walk_start) begin
        wlk_r <= '0;
      end else if (issue) begin
        wlk_r <= wlk_r + 1'b1;
      end
      rd_vld_r <= issue;
    end
  end

  // Read the table, registered
  always_ff @(posedge clk) begin
    rd_idx_r  <= wlk_r[IDX_W-1:0];
    rd_data_r <= mem[wlk_r[IDX_W-1:0]];
  end

  // Write the new entry on admission, or lower a later slack during the update walk
  always_ff @(posedge clk) begin
    if (commit_we) begin
      mem[pos] <= '{duration: dur_r, slack: dl_r - need_r};
    end else if (upd_we) begin
      mem[rd_idx_r] <= '{duration: rd_data_r.duration,
                         slack: rd_data_r.slack - {{(DL_W-DUR_W){1'b0}}, dur_r}};
    end
  end

  // Sum earlier durations onto the own duration; flag a later slack below it
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      need_r <= {{(DL_W-DUR_W){1'b0}}, in_duration};
      late_r <= 1'b0;
    end else if (!cmd.upd_mode && hit_valid) begin
      if (rd_idx_r < pos) begin
        need_r <= need_r + {{(DL_W-DUR_W){1'b0}}, rd_data_r.duration};
      end
      if ((rd_idx_r > pos) &&
          (rd_data_r.slack < {{(DL_W-DUR_W){1'b0}}, dur_r})) begin
        late_r <= 1'b1;
      end
    end
  end

  // Hold valid bits and admission count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (commit_we) begin
      valid_r[pos] <= 1'b1;
      count_r      <= count_inc;
    end
  end

  // Post the result beat
  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      res_status_r <= STS_TAKEN;
      res_count_r  <= count_r;
      res_slack_r  <= '0;
    end else if (cmd.decide) begin
      if (own_late) begin
        res_status_r <= STS_OWN_LATE;
      end else if (late_r) begin
        res_status_r <= STS_LATER_LATE;
      end else begin
        res_status_r <= STS_ADMIT;
      end
      res_count_r <= sts.pass_ok ? count_inc : count_r;
      res_slack_r <= sts.pass_ok ? dl_r - need_r : '0;
    end
  end

  assign out_status         = res_status_r;
  assign out_admitted_count = res_count_r;
  assign out_new_slack      = res_slack_r;

endmodule

// ===== sv/deadline_slot_admission.sv =====
// Top level: deadline-ordered slot admission test, controller plus datapath.
`timescale 1ns / 1ps
// Offer a task with start while busy is low; exactly one result beat follows,
// marked by out_valid for a single cycle, and it cannot be held off, so the
// receiver must take it then. Busy stays high from the accepting edge until
// the result cycle ends. A taken or out-of-range slot is answered after the
// check alone. Otherwise each offer walks the single-read-port slot table of
// min(SLOTS, 64) entries once to sum earlier durations and check later slack,
// and an admitted offer walks it again to lower the slack of later slots.
// Slack entries are only read for valid slots, so the table needs no clearing
// after reset.
module deadline_slot_admission #(
  parameter int SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dsa_pkg::SLOT_W-1:0]    in_slot,
  input  logic [dsa_pkg::DUR_W-1:0]     in_duration,
  input  logic [dsa_pkg::DL_W-1:0]      in_deadline,
  output logic                          out_valid,
  output logic [dsa_pkg::STATUS_W-1:0]  out_status,
  output logic [dsa_pkg::COUNT_W-1:0]   out_admitted_count,
  output logic [dsa_pkg::DL_W-1:0]      out_new_slack
);
  import dsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  dsa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_slot            (in_slot),
    .in_duration        (in_duration),
    .in_deadline        (in_deadline),
    .sts                (sts),
    .out_status         (out_status),
    .out_admitted_count (out_admitted_count),
    .out_new_slack      (out_new_slack)
  );

endmodule

// ===== verif/testbench.sv =====
// Testbench: self-checking random and directed regression of the slot admission block.
`timescale 1ns / 1ps
module testbench;
  import dsa_pkg::*;

  localparam int          LIMIT   = 2_000_000;
  localparam bit [63:0]   MAX_DUR = 64'hFFFF_FFFF;
  localparam bit [63:0]   MAX_DL  = 64'hFF_FFFF_FFFF;
  localparam int          OFFERS  = 1900;
  // Longest answer: an admission walks the table twice
  localparam int          SETTLE  = 2 * SLOT_SPAN + 12;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [SLOT_W-1:0]    in_slot;
  logic [DUR_W-1:0]     in_duration;
  logic [DL_W-1:0]      in_deadline;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [COUNT_W-1:0]   out_admitted_count;
  logic [DL_W-1:0]      out_new_slack;

  typedef struct {
    status_t             status;
    logic [COUNT_W-1:0]  count;
    logic [DL_W-1:0]     slack;
  } verdict_t;

  // Mirror of the admission table; predicts one verdict per accepted offer
  class admission_board;
    bit [DUR_W-1:0]    dur_tab   [SLOT_SPAN];
    bit [DL_W-1:0]     slack_tab [SLOT_SPAN];
    bit                valid_tab [SLOT_SPAN];
    bit [COUNT_W-1:0]  admit_cnt;
    verdict_t          verdicts_due [$];
    int unsigned       faults;

    function bit [63:0] earlier_sum(int p);
      bit [63:0] sum;
      sum = '0;
      for (int i = 0; i < p; i++)
        if (valid_tab[i]) sum += dur_tab[i];
      return sum;
    endfunction

    // Least slack of the valid slots at or after p
    function bit [DL_W-1:0] later_min(int p, output bit found);
      bit [DL_W-1:0] least;
      least = '0;
      found = 1'b0;
      for (int i = p; i < SLOT_SPAN; i++)
        if (valid_tab[i] && (!found || slack_tab[i] < least)) begin
          least = slack_tab[i];
          found = 1'b1;
        end
      return least;
    endfunction

    function void note_offer(bit [SLOT_W-1:0] slot, bit [DUR_W-1:0] dur,
                             bit [DL_W-1:0] dl);
      verdict_t       v;
      bit [63:0]      need;
      bit [DL_W-1:0]  least;
      bit             found;
      v.status = STS_ADMIT;
      v.slack  = '0;
      // A 6-bit slot always lies inside a 64-entry table, so only a taken slot rejects here
      if (valid_tab[slot]) begin
        v.status = STS_TAKEN;
      end else begin
        need = earlier_sum(slot) + dur;
        if (need > dl) begin
          v.status = STS_OWN_LATE;
        end else begin
          least = later_min(slot, found);
          if (found && least < dur) begin
            v.status = STS_LATER_LATE;
          end else begin
            v.slack         = dl - need;
            dur_tab[slot]   = dur;
            slack_tab[slot] = dl - need;
            valid_tab[slot] = 1'b1;
            for (int i = slot + 1; i < SLOT_SPAN; i++)
              if (valid_tab[i]) slack_tab[i] -= dur;
            if (admit_cnt != COUNT_MAX) admit_cnt++;
          end
        end
      end
      v.count = admit_cnt;
      verdicts_due = {verdicts_due, v};
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [COUNT_W-1:0] cnt,
                               logic [DL_W-1:0] sl);
      verdict_t v;
      if (verdicts_due.size() == 0) begin
        $error("result beat with no offer outstanding: status %0d", st);
        faults++;
        return;
      end
      v = verdicts_due.pop_front();
      if (st !== v.status) begin
        $error("status: expected %0d, got %0d", v.status, st);
        faults++;
      end
      if (cnt !== v.count) begin
        $error("admitted_count: expected %0d, got %0d", v.count, cnt);
        faults++;
      end
      if (sl !== v.slack) begin
        $error("new_slack: expected %0h, got %0h", v.slack, sl);
        faults++;
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  admission_board board;
  int unsigned    cycles;
  bit             no_idle;

  deadline_slot_admission uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_slot            (in_slot),
    .in_duration        (in_duration),
    .in_deadline        (in_deadline),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_admitted_count (out_admitted_count),
    .out_new_slack      (out_new_slack)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Take every result beat; the block cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_result(out_status, out_admitted_count, out_new_slack);
  end

  function automatic bit [63:0] rand_upto(bit [63:0] hi);
    if (hi == 0) return 0;
    return {$urandom, $urandom} % (hi + 1);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // Drive one offer from a falling edge and hold it until the block takes it
  task automatic offer(bit [SLOT_W-1:0] slot, bit [DUR_W-1:0] dur, bit [DL_W-1:0] dl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_slot     = slot;
    in_duration = dur;
    in_deadline = dl;
    start       = 1'b1;
    do @(posedge clk); while (busy);
    board.note_offer(slot, dur, dl);
    @(negedge clk);
  endtask

  // Shape one offer towards a chosen outcome from the mirrored table
  task automatic offer_random();
    int             free_q [$];
    int             taken_q [$];
    int             late_q [$];
    int             kind;
    int             p;
    bit             found;
    bit [DL_W-1:0]  least;
    bit [63:0]      cap;
    bit [63:0]      dur;
    bit [63:0]      need;
    bit [63:0]      dl;
    kind = $urandom_range(0, 999);
    for (int i = 0; i < SLOT_SPAN; i++) begin
      if (board.valid_tab[i]) begin
        taken_q = {taken_q, i};
      end else begin
        free_q = {free_q, i};
        least = board.later_min(i, found);
        if (found && least < MAX_DUR) late_q = {late_q, i};
      end
    end
    // Noise by default
    p   = $urandom_range(0, SLOT_SPAN - 1);
    dur = $urandom;
    dl  = {$urandom_range(0, 255), $urandom};
    if (kind < 20 && free_q.size() > 0) begin
      // Admission: duration within the later slack, deadline at or past the need
      p     = free_q[$urandom_range(0, free_q.size() - 1)];
      least = board.later_min(p, found);
      cap   = (found && least < MAX_DUR) ? 64'(least) : MAX_DUR;
      dur   = rand_upto(cap);
      case ($urandom_range(0, 9))
        0:       dur = cap;
        1, 2, 3: ;
        default: dur = dur >> $urandom_range(0, 31);
      endcase
      need = board.earlier_sum(p) + dur;
      case ($urandom_range(0, 9))
        0:       dl = need;
        1, 2, 3: dl = need + rand_upto((MAX_DL - need > 255) ? 64'd255 : MAX_DL - need);
        default: dl = need + rand_upto(MAX_DL - need);
      endcase
    end else if (kind < 80) begin
    end else if (kind < 230 && taken_q.size() > 0) begin
      p = taken_q[$urandom_range(0, taken_q.size() - 1)];
    end else if (kind < 600 && late_q.size() > 0) begin
      // Later task would miss: exceed the least later slack, meet the own deadline
      p     = late_q[$urandom_range(0, late_q.size() - 1)];
      least = board.later_min(p, found);
      dur   = 64'(least) + 1;
      if ($urandom_range(0, 3) != 0) dur += rand_upto(MAX_DUR - least - 1);
      need = board.earlier_sum(p) + dur;
      dl   = need + rand_upto(MAX_DL - need);
    end else if (free_q.size() > 0) begin
      // Own deadline missed by at least one
      p    = free_q[$urandom_range(0, free_q.size() - 1)];
      dur  = $urandom;
      need = board.earlier_sum(p) + dur;
      if (need == 0) begin
        dur  = 1;
        need = 1;
      end
      dl = ($urandom_range(0, 3) == 0) ? need - 1 : rand_upto(need - 1);
    end
    offer(p[SLOT_W-1:0], dur[DUR_W-1:0], dl[DL_W-1:0]);
  endtask

  initial begin
    board       = new();
    cycles      = 0;
    no_idle     = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_slot     = '0;
    in_duration = '0;
    in_deadline = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, every status, boundary fits and test order
    offer(0, 0, 0);                                // zero task into an empty table
    offer(0, 1, MAX_DL[DL_W-1:0]);                 // slot already taken
    offer(63, MAX_DUR[DUR_W-1:0], MAX_DL[DL_W-1:0]); // top slot, largest fields
    offer(5, 1, 0);                                // own deadline missed
    offer(10, 10, 20);
    offer(9, 11, MAX_DL[DL_W-1:0]);                // later slack one short
    offer(9, 10, 10);                              // both tests met exactly
    offer(8, 0, 0);                                // zero duration against zero slack
    offer(7, 1, 0);                                // both tests fail, own deadline first
    offer(7, 1, MAX_DL[DL_W-1:0]);                 // later task would miss
    offer(11, 1, 20);
    offer(11, 1, 21);
    offer(63, 0, 0);
    offer(32, MAX_DUR[DUR_W-1:0], MAX_DL[DL_W-1:0]);
    offer(40, MAX_DUR[DUR_W-1:0], 0);
    offer(1, 5, 4);
    offer(62, 0, MAX_DL[DL_W-1:0]);
    offer(2, MAX_DUR[DUR_W-1:0], MAX_DL[DL_W-1:0]);

    // Random: shaped offers with occasional back-to-back stretches
    for (int n = 18; n < OFFERS; n++) begin
      if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      offer_random();
    end
    start = 1'b0;

    // Drain, then watch for stray beats
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.faults == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
